// ===== hdl/nsc_pkg.sv =====
// ----------------------------------------------------------------------------
// nsc_pkg
// Shared constants and types for the non-overlapping substring counter.
// ----------------------------------------------------------------------------
package nsc_pkg;

  localparam int MAX_PATTERN  = 32;
  localparam int LEN_W        = 6;
  localparam int WORD_W       = 64;
  localparam int PATTERN_REGS = 4;
  localparam int REG_BYTES    = WORD_W / 8;
  localparam int STORED_BYTES = PATTERN_REGS * REG_BYTES;
  localparam int COUNT_W      = 32;
  localparam int SEEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int POS_W        = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int CFG_IDX_W    = 3;

  typedef logic [7:0] byte_t;
  typedef byte_t [MAX_PATTERN-1:0] window_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LENGTH  = 3'd0,
    CFG_BYTES_0 = 3'd1,
    CFG_BYTES_1 = 3'd2,
    CFG_BYTES_2 = 3'd3,
    CFG_BYTES_3 = 3'd4
  } cfg_index_t;

  typedef struct packed {
    logic [LEN_W-1:0] length;
    window_t          bytes;
  } pattern_cfg_t;

endpackage

// ===== hdl/nonoverlap_substring_counter.sv =====
// ----------------------------------------------------------------------------
// nonoverlap_substring_counter
// Counts non-overlapping occurrences of a configured pattern in a byte stream.
// ----------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  text     in   text_valid/text_stall   text_byte, end_of_text
//  count    out  count_valid/count_stall match_count
//  cfg      in   cfg_valid/cfg_ready     cfg_index, cfg_data
//
//  One transaction per cycle while text_stall is low; an input register feeds
//  the window update and the parallel compare, which load the count register.
//  An end transaction passes the input register, then loads match_count.
//  Synchronous reset clears all control state and the pattern registers.
//  A stalled count output holds back only end transactions and the bytes behind them.
// ----------------------------------------------------------------------------
module nonoverlap_substring_counter (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              text_valid,
  output logic                              text_stall,
  input  logic [7:0]                        text_byte,
  input  logic                              end_of_text,
  output logic                              count_valid,
  input  logic                              count_stall,
  output logic [nsc_pkg::COUNT_W-1:0]       match_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nsc_pkg::WORD_W-1:0]        cfg_data
);

  logic [nsc_pkg::LEN_W-1:0]   pattern_length;
  logic [nsc_pkg::WORD_W-1:0]  pattern_words [nsc_pkg::PATTERN_REGS];
  nsc_pkg::pattern_cfg_t       pattern;

  logic                        s1_valid;
  nsc_pkg::byte_t              s1_byte;
  logic                        s1_end;
  logic                        s1_go;

  nsc_pkg::window_t            window;
  nsc_pkg::window_t            window_next;
  logic [nsc_pkg::SEEN_W-1:0]  seen;
  logic [nsc_pkg::SEEN_W-1:0]  seen_next;
  logic [nsc_pkg::POS_W-1:0]   skip;
  logic [nsc_pkg::COUNT_W-1:0] total;
  logic                        hit;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      for (int r = 0; r < nsc_pkg::PATTERN_REGS; r++) begin
        pattern_words[r] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (nsc_pkg::cfg_index_t'(cfg_index))
        nsc_pkg::CFG_LENGTH:  pattern_length   <= cfg_data[nsc_pkg::LEN_W-1:0];
        nsc_pkg::CFG_BYTES_0: pattern_words[0] <= cfg_data;
        nsc_pkg::CFG_BYTES_1: pattern_words[1] <= cfg_data;
        nsc_pkg::CFG_BYTES_2: pattern_words[2] <= cfg_data;
        nsc_pkg::CFG_BYTES_3: pattern_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pattern.length = pattern_length;
    for (int k = 0; k < nsc_pkg::MAX_PATTERN; k++) begin
      if (k < nsc_pkg::STORED_BYTES) begin
        pattern.bytes[k] = pattern_words[k / nsc_pkg::REG_BYTES]
                                        [(k % nsc_pkg::REG_BYTES) * 8 +: 8];
      end else begin
        pattern.bytes[k] = '0;
      end
    end
  end

  // Byte transactions never wait on the output; end transactions need a free slot.
  assign s1_go      = s1_valid && (!s1_end || !count_valid || !count_stall);
  assign text_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_valid || s1_go) begin
      s1_valid <= text_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (text_valid && !text_stall) begin
      s1_byte <= text_byte;
      s1_end  <= end_of_text;
    end
  end

  always_comb begin
    window_next[0] = s1_byte;
    for (int k = 1; k < nsc_pkg::MAX_PATTERN; k++) begin
      window_next[k] = window[k-1];
    end
    if (int'(seen) < nsc_pkg::MAX_PATTERN) begin
      seen_next = seen + nsc_pkg::SEEN_W'(1);
    end else begin
      seen_next = seen;
    end
  end

  nsc_matcher u_matcher (
    .window  (window_next),
    .seen    (seen_next),
    .pattern (pattern),
    .hit     (hit)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      seen  <= '0;
      skip  <= '0;
      total <= '0;
    end else if (s1_go) begin
      if (s1_end) begin
        seen  <= '0;
        skip  <= '0;
        total <= '0;
      end else begin
        seen <= seen_next;
        if (skip != '0) begin
          skip <= skip - nsc_pkg::POS_W'(1);
        end else if (hit) begin
          skip <= nsc_pkg::POS_W'(pattern_length - nsc_pkg::LEN_W'(1));
          if (total != '1) begin
            total <= total + nsc_pkg::COUNT_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && !s1_end) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_valid <= 1'b0;
    end else if (s1_go && s1_end) begin
      count_valid <= 1'b1;
    end else if (!count_stall) begin
      count_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_end) begin
      match_count <= total;
    end
  end

endmodule

// ===== hdl/nsc_matcher.sv =====
// ----------------------------------------------------------------------------
// nsc_matcher
// Parallel compare of the updated byte window against the aligned pattern.
// ----------------------------------------------------------------------------
module nsc_matcher (
  input  nsc_pkg::window_t                  window,
  input  logic [nsc_pkg::SEEN_W-1:0]        seen,
  input  nsc_pkg::pattern_cfg_t             pattern,
  output logic                              hit
);

  logic                        all_eq;
  logic [nsc_pkg::POS_W-1:0]   pos [nsc_pkg::MAX_PATTERN];

  always_comb begin
    all_eq = 1'b1;
    for (int i = 0; i < nsc_pkg::MAX_PATTERN; i++) begin
      pos[i] = nsc_pkg::POS_W'(int'(pattern.length) - 1 - i);
      if (i < int'(pattern.length)) begin
        if (window[pos[i]] != pattern.bytes[i]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign hit = (pattern.length != '0) &&
               (int'(pattern.length) <= nsc_pkg::MAX_PATTERN) &&
               (int'(seen) >= int'(pattern.length)) &&
               all_eq;

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for nonoverlap_substring_counter. Loads patterns of many
// lengths, streams texts built around them under random gaps and output
// stalls, predicts each count from a local window and skip model, and checks
// every count transaction in order.
// ----------------------------------------------------------------------------
module tb_top;

  class count_scoreboard;
    logic [nsc_pkg::LEN_W-1:0]   pat_len;
    logic [nsc_pkg::WORD_W-1:0]  pat_word [nsc_pkg::PATTERN_REGS];
    nsc_pkg::byte_t              window [nsc_pkg::MAX_PATTERN];
    int unsigned                 seen;
    int unsigned                 skip;
    logic [nsc_pkg::COUNT_W-1:0] hits;
    logic [nsc_pkg::COUNT_W-1:0] expected_counts [$];
    int                          errors;

    function new();
      pat_len = '0;
      foreach (pat_word[k]) pat_word[k] = '0;
      errors = 0;
      clear_text();
    endfunction

    function void clear_text();
      foreach (window[k]) window[k] = '0;
      seen = 0;
      skip = 0;
      hits = '0;
    endfunction

    function void write_reg(logic [nsc_pkg::CFG_IDX_W-1:0] idx,
                            logic [nsc_pkg::WORD_W-1:0] data);
      case (nsc_pkg::cfg_index_t'(idx))
        nsc_pkg::CFG_LENGTH:  pat_len = data[nsc_pkg::LEN_W-1:0];
        nsc_pkg::CFG_BYTES_0: pat_word[0] = data;
        nsc_pkg::CFG_BYTES_1: pat_word[1] = data;
        nsc_pkg::CFG_BYTES_2: pat_word[2] = data;
        nsc_pkg::CFG_BYTES_3: pat_word[3] = data;
        default: ;
      endcase
    endfunction

    function nsc_pkg::byte_t pattern_byte(int unsigned i);
      if (i >= nsc_pkg::STORED_BYTES) return '0;
      return pat_word[i / nsc_pkg::REG_BYTES][(i % nsc_pkg::REG_BYTES) * 8 +: 8];
    endfunction

    function bit window_hit(int unsigned len);
      for (int unsigned i = 0; i < len; i++)
        if (window[len - 1 - i] != pattern_byte(i)) return 1'b0;
      return 1'b1;
    endfunction

    function void note_text(nsc_pkg::byte_t b, logic eot);
      int unsigned len;
      len = pat_len;
      if (eot) begin
        expected_counts.push_back(hits);
        clear_text();
        return;
      end
      for (int i = nsc_pkg::MAX_PATTERN - 1; i > 0; i--) window[i] = window[i - 1];
      window[0] = b;
      if (seen < nsc_pkg::MAX_PATTERN) seen++;
      if (skip > 0) begin
        skip--;
        return;
      end
      if (len != 0 && len <= nsc_pkg::MAX_PATTERN && seen >= len && window_hit(len)) begin
        if (hits != '1) hits++;
        skip = len - 1;
      end
    endfunction

    function void check_count(logic [nsc_pkg::COUNT_W-1:0] actual);
      logic [nsc_pkg::COUNT_W-1:0] want;
      if (expected_counts.size() == 0) begin
        $error("match_count: expected none, actual %0d", actual);
        errors++;
        return;
      end
      want = expected_counts.pop_front();
      if (actual !== want) begin
        $error("match_count: expected %0d, actual %0d", want, actual);
        errors++;
      end
    endfunction

    function int pending();
      return expected_counts.size();
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          text_valid;
  logic                          text_stall;
  logic [7:0]                    text_byte;
  logic                          end_of_text;
  logic                          count_valid;
  logic                          count_stall;
  logic [nsc_pkg::COUNT_W-1:0]   match_count;
  logic                          cfg_valid;
  logic                          cfg_ready;
  logic [nsc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [nsc_pkg::WORD_W-1:0]    cfg_data;

  count_scoreboard sb;
  bit              fast_text;
  int              items_sent = 0;

  nonoverlap_substring_counter u_top (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .count_valid (count_valid),
    .count_stall (count_stall),
    .match_count (match_count),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (text_valid && !text_stall) sb.note_text(text_byte, end_of_text);
      if (count_valid && !count_stall) sb.check_count(match_count);
    end
  end

  task automatic send_item(input nsc_pkg::byte_t b, input logic eot);
    int gap;
    gap = fast_text ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      text_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    text_byte   <= b;
    end_of_text <= eot;
    text_valid  <= 1'b1;
    @(posedge clk);
    while (text_stall) @(posedge clk);
    items_sent++;
  endtask

  task automatic write_reg(input logic [nsc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [nsc_pkg::WORD_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_pattern(input logic [nsc_pkg::LEN_W-1:0] len, input bit junk_high,
                              input nsc_pkg::byte_t pat [nsc_pkg::STORED_BYTES]);
    logic [nsc_pkg::WORD_W-1:0]    word;
    logic [nsc_pkg::CFG_IDX_W-1:0] spare;
    word = junk_high ? {$urandom, $urandom} : '0;
    word[nsc_pkg::LEN_W-1:0] = len;
    if ($urandom_range(0, 3) == 0) begin
      spare = nsc_pkg::CFG_IDX_W'(nsc_pkg::CFG_BYTES_3 + $urandom_range(1, 3));
      write_reg(spare, {$urandom, $urandom});
    end
    write_reg(nsc_pkg::CFG_LENGTH, word);
    for (int k = 0; k < nsc_pkg::PATTERN_REGS; k++) begin
      for (int j = 0; j < nsc_pkg::REG_BYTES; j++)
        word[j*8 +: 8] = pat[k*nsc_pkg::REG_BYTES + j];
      write_reg(nsc_pkg::cfg_index_t'(nsc_pkg::CFG_BYTES_0 + k), word);
    end
    cfg_valid <= 1'b0;
  endtask

  // drain counts, then let the pipeline empty before touching registers
  task automatic quiesce();
    text_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic random_phase();
    nsc_pkg::byte_t pat [nsc_pkg::STORED_BYTES];
    nsc_pkg::byte_t alpha [2];
    int    len, r, budget, sent0;
    bit    narrow;
    narrow   = $urandom_range(0, 3) != 0;
    alpha[0] = nsc_pkg::byte_t'($urandom);
    alpha[1] = nsc_pkg::byte_t'($urandom);
    r = $urandom_range(0, 19);
    if (r < 2) len = 0;
    else if (r < 4) len = $urandom_range(nsc_pkg::MAX_PATTERN + 1, 63);
    else if (r < 7) len = nsc_pkg::MAX_PATTERN;
    else if (r < 13) len = $urandom_range(1, 3);
    else len = $urandom_range(1, nsc_pkg::MAX_PATTERN);
    foreach (pat[i])
      pat[i] = narrow ? alpha[$urandom_range(0, 1)] : nsc_pkg::byte_t'($urandom);
    load_pattern(nsc_pkg::LEN_W'(len), 1'($urandom_range(0, 1)), pat);
    fast_text = $urandom_range(0, 3) == 0;
    budget = $urandom_range(60, 200);
    sent0 = items_sent;
    while (items_sent - sent0 < budget) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        send_item(nsc_pkg::byte_t'($urandom), 1'b1);
      end else if (r < 40 && len >= 1 && len <= nsc_pkg::MAX_PATTERN) begin
        for (int i = 0; i < len; i++)
          send_item(($urandom_range(0, 15) == 0) ? nsc_pkg::byte_t'($urandom) : pat[i],
                    1'b0);
      end else if (narrow && $urandom_range(0, 3) != 0) begin
        send_item(alpha[$urandom_range(0, 1)], 1'b0);
      end else begin
        send_item(nsc_pkg::byte_t'($urandom), 1'b0);
      end
    end
    // leave some texts open so the next pattern lands mid-text
    if ($urandom_range(0, 3) != 0) send_item(nsc_pkg::byte_t'($urandom), 1'b1);
    quiesce();
  endtask

  initial begin : count_sink
    int gap;
    int taken;
    taken = 0;
    count_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken == 20) gap = 600;
      else if ($urandom_range(0, 2) == 0) gap = 0;
      else gap = $urandom_range(0, 19);
      if (gap > 0) begin
        count_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      count_stall <= 1'b0;
      @(posedge clk);
      while (count_valid !== 1'b1) @(posedge clk);
      taken++;
    end
  end

  initial begin : stimulus
    nsc_pkg::byte_t pat [nsc_pkg::STORED_BYTES];
    sb = new();
    text_valid  <= 1'b0;
    text_byte   <= '0;
    end_of_text <= 1'b0;
    cfg_valid   <= 1'b0;
    cfg_index   <= nsc_pkg::CFG_LENGTH;
    cfg_data    <= '0;
    fast_text   = 1'b1;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'hA5, 1'b1);
    quiesce();

    foreach (pat[i]) pat[i] = 8'hFF;
    pat[0] = 8'h00;
    pat[1] = 8'h00;
    load_pattern(nsc_pkg::LEN_W'(2), 1'b1, pat);
    repeat (5) send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b1);
    send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    quiesce();

    load_pattern(nsc_pkg::LEN_W'(nsc_pkg::MAX_PATTERN + 1), 1'b0, pat);
    repeat (3) send_item(8'h00, 1'b0);
    send_item(8'h00, 1'b1);
    quiesce();

    foreach (pat[i]) pat[i] = 8'hFF;
    load_pattern(nsc_pkg::LEN_W'(1), 1'b0, pat);
    send_item(8'hFF, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b1);
    quiesce();

    while (items_sent < 1620) random_phase();

    repeat (10) @(posedge clk);
    if (sb.errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #10000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/nsc_pkg.sv
hdl/nsc_matcher.sv
hdl/nonoverlap_substring_counter.sv
tb/sv/tb_top.sv
